// File: rtl/core/dbpt_pkg.sv
// ----------------------------------------------------------------------------
// dbpt_pkg
// Shared types, codes and sizes of the DMA buffer pool tracker.
// ----------------------------------------------------------------------------
package dbpt_pkg;

   localparam int MAX_BUFFERS = 16;
   localparam int IDX_W       = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
   localparam int POOL_W      = 9;   // holds any pool size up to 256
   localparam int QUEUE_DEPTH = 2;

   localparam logic [15:0] WAIT_LIMIT_MAX = 16'd30000;

   // request kinds
   localparam logic [2:0] KIND_RESERVE  = 3'd0;
   localparam logic [2:0] KIND_RELEASE  = 3'd1;
   localparam logic [2:0] KIND_START    = 3'd2;
   localparam logic [2:0] KIND_FINISH   = 3'd3;
   localparam logic [2:0] KIND_COMPLETE = 3'd4;

   // outcome codes
   localparam logic [3:0] OC_OK            = 4'd0;
   localparam logic [3:0] OC_NONE_FREE     = 4'd1;
   localparam logic [3:0] OC_BAD_INDEX     = 4'd2;
   localparam logic [3:0] OC_TOO_LONG      = 4'd3;
   localparam logic [3:0] OC_NOT_PERMITTED = 4'd4;
   localparam logic [3:0] OC_ALREADY       = 4'd5;
   localparam logic [3:0] OC_BAD_TIMEOUT   = 4'd6;
   localparam logic [3:0] OC_TIMED_OUT     = 4'd7;
   localparam logic [3:0] OC_XFER_ERROR    = 4'd8;

   // configuration register indexes
   localparam logic [1:0] CSR_POOL_BUFFERS = 2'd0;
   localparam logic [1:0] CSR_SLOT_BYTES   = 2'd1;
   localparam logic [1:0] CSR_POOL_BASE    = 2'd2;

   typedef enum logic [1:0] {
      PH_FREE     = 2'd0,
      PH_RESERVED = 2'd1,
      PH_RUNNING  = 2'd2,
      PH_DONE     = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      OP_RESERVE  = 3'd0,
      OP_RELEASE  = 3'd1,
      OP_START    = 3'd2,
      OP_FINISH   = 3'd3,
      OP_COMPLETE = 3'd4,
      OP_REJECT   = 3'd5
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] index;
      logic [3:0] reject_oc;
      logic       engine_ok;
   } cmd_type;

   typedef struct packed {
      logic [POOL_W-1:0] pool_size;
      logic [24:0]       slot_bytes;
      logic [31:0]       base_address;
   } cfg_type;

endpackage

// File: rtl/core/dbpt_front.sv
// ----------------------------------------------------------------------------
// dbpt_front
// Classifies a request: checks index, length and timeout, and turns it into
// a command for the back end, or a reject carrying its outcome.
// ----------------------------------------------------------------------------
module dbpt_front import dbpt_pkg::*; (
   input  cfg_type     cfg,
   input  logic [2:0]  kind,
   input  logic [7:0]  slot_index,
   input  logic [23:0] transfer_length,
   input  logic [15:0] wait_limit_ms,
   input  logic        engine_ok,
   output cmd_type     cmd
);

   logic index_ok;
   logic too_long;
   logic bad_wait;

   assign index_ok = {1'b0, slot_index} < cfg.pool_size;
   assign too_long = {1'b0, transfer_length} > cfg.slot_bytes;
   assign bad_wait = wait_limit_ms >= WAIT_LIMIT_MAX;

   always_comb begin
      cmd.index     = slot_index;
      cmd.engine_ok = engine_ok;
      cmd.reject_oc = OC_NOT_PERMITTED;
      cmd.op        = OP_REJECT;
      case (kind)
         KIND_RESERVE: begin
            cmd.op = OP_RESERVE;
         end
         KIND_RELEASE, KIND_START, KIND_FINISH, KIND_COMPLETE: begin
            if (!index_ok) begin
               cmd.reject_oc = OC_BAD_INDEX;
            end else if (kind == KIND_START && too_long) begin
               cmd.reject_oc = OC_TOO_LONG;
            end else if (kind == KIND_FINISH && bad_wait) begin
               cmd.reject_oc = OC_BAD_TIMEOUT;
            end else if (kind == KIND_RELEASE) begin
               cmd.op = OP_RELEASE;
            end else if (kind == KIND_START) begin
               cmd.op = OP_START;
            end else if (kind == KIND_FINISH) begin
               cmd.op = OP_FINISH;
            end else begin
               cmd.op = OP_COMPLETE;
            end
         end
         default: begin
            cmd.op = OP_REJECT;
         end
      endcase
   end

endmodule

// File: rtl/core/dbpt_queue.sv
// ----------------------------------------------------------------------------
// dbpt_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module dbpt_queue import dbpt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head_cmd
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = count_ff == CNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/dbpt_back.sv
// ----------------------------------------------------------------------------
// dbpt_back
// Buffer state table and command execution: lowest-free search, phase
// updates, then offset and address into the response register.
// ----------------------------------------------------------------------------
module dbpt_back import dbpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        q_empty,
   input  cmd_type     q_head,
   output logic        q_pop,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_outcome,
   output logic [7:0]  rsp_granted_index,
   output logic [31:0] rsp_byte_offset,
   output logic [31:0] rsp_bus_address
);

   typedef enum logic [1:0] {
      BK_EXEC = 2'b01,
      BK_LOAD = 2'b10
   } back_state_type;

   back_state_type   state_ff, state_in;
   phase_type        phase_ff [MAX_BUFFERS];
   phase_type        phase_in [MAX_BUFFERS];
   logic [MAX_BUFFERS-1:0] failed_ff, failed_in;

   logic [3:0]  oc_ff, oc_in;
   logic [7:0]  gidx_ff, gidx_in;
   logic        grant_ff, grant_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [3:0]  outcome_ff;
   logic [7:0]  granted_ff;
   logic [31:0] offset_ff;
   logic [31:0] address_ff;

   logic [IDX_W-1:0] slot;
   logic [IDX_W-1:0] free_sel;
   logic             free_found;
   logic [32:0]      product;
   logic [31:0]      offset;
   logic             out_free;
   logic             load;

   assign slot = q_head.index[IDX_W-1:0];

   // lowest free buffer inside the pool
   always_comb begin
      free_sel   = '0;
      free_found = 1'b0;
      for (int i = MAX_BUFFERS - 1; i >= 0; i--) begin
         if (phase_ff[i] == PH_FREE && POOL_W'(i) < cfg.pool_size) begin
            free_sel   = IDX_W'(i);
            free_found = 1'b1;
         end
      end
   end

   assign q_pop = (state_ff == BK_EXEC) && !q_empty;

   always_comb begin
      phase_in  = phase_ff;
      failed_in = failed_ff;
      oc_in     = oc_ff;
      gidx_in   = gidx_ff;
      grant_in  = grant_ff;
      if (q_pop) begin
         oc_in    = OC_OK;
         gidx_in  = q_head.index;
         grant_in = 1'b0;
         case (q_head.op)
            OP_RESERVE: begin
               if (free_found) begin
                  phase_in[free_sel] = PH_RESERVED;
                  gidx_in            = 8'(free_sel);
                  grant_in           = 1'b1;
               end else begin
                  oc_in = OC_NONE_FREE;
               end
            end
            OP_RELEASE: begin
               if (phase_ff[slot] == PH_FREE) begin
                  oc_in = OC_NOT_PERMITTED;
               end else begin
                  phase_in[slot]  = PH_FREE;
                  failed_in[slot] = 1'b0;
               end
            end
            OP_START: begin
               if (phase_ff[slot] == PH_RESERVED) begin
                  phase_in[slot]  = PH_RUNNING;
                  failed_in[slot] = 1'b0;
               end else if (phase_ff[slot] == PH_RUNNING) begin
                  oc_in = OC_ALREADY;
               end else begin
                  oc_in = OC_NOT_PERMITTED;
               end
            end
            OP_FINISH: begin
               if (phase_ff[slot] == PH_RUNNING) begin
                  oc_in = OC_TIMED_OUT;
               end else if (phase_ff[slot] == PH_DONE) begin
                  oc_in = failed_ff[slot] ? OC_XFER_ERROR : OC_OK;
               end else begin
                  oc_in = OC_NOT_PERMITTED;
               end
            end
            OP_COMPLETE: begin
               phase_in[slot]  = PH_DONE;
               failed_in[slot] = !q_head.engine_ok;
               oc_in           = q_head.engine_ok ? OC_OK : OC_XFER_ERROR;
            end
            default: begin
               oc_in = q_head.reject_oc;
            end
         endcase
      end
   end

   assign product  = 33'(gidx_ff) * 33'(cfg.slot_bytes);
   assign offset   = grant_ff ? product[31:0] : 32'd0;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load     = (state_ff == BK_LOAD) && out_free;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         BK_EXEC: begin
            if (q_pop) begin
               state_in = BK_LOAD;
            end
         end
         BK_LOAD: begin
            if (out_free) begin
               state_in     = BK_EXEC;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = BK_EXEC;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_EXEC;
         rsp_valid_ff <= 1'b0;
         failed_ff    <= '0;
         for (int i = 0; i < MAX_BUFFERS; i++) begin
            phase_ff[i] <= PH_FREE;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         failed_ff    <= failed_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      oc_ff    <= oc_in;
      gidx_ff  <= gidx_in;
      grant_ff <= grant_in;
      if (load) begin
         outcome_ff <= oc_ff;
         granted_ff <= gidx_ff;
         offset_ff  <= offset;
         address_ff <= grant_ff ? cfg.base_address + offset : 32'd0;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_outcome       = outcome_ff;
   assign rsp_granted_index = granted_ff;
   assign rsp_byte_offset   = offset_ff;
   assign rsp_bus_address   = address_ff;

endmodule

// File: rtl/core/dma_buffer_pool_tracker.sv
// ----------------------------------------------------------------------------
// dma_buffer_pool_tracker
// Tracks phase and error mark of a pool of equal-sized DMA buffers.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per transfer (reserve, release, start, finish
//   query, engine completion); rsp_* returns exactly one response per
//   request, in order. csr_* writes pool size, buffer size and pool base
//   address; write only while no request is outstanding.
//   The front end classifies a request in the cycle it is taken and pushes
//   it into a two-entry queue; req_stall is high while the queue is full.
//   The back end executes one command at a time in two states: EXEC for the
//   lowest-free search and state update, then LOAD for the offset multiply
//   and address add into the response register. It takes the next command
//   only after the response of the last one is loaded.
//   When rsp_stall is high the response holds; the back end finishes the
//   next command and waits, and the queue keeps taking requests until full.
//   Reset is synchronous: all buffers become free with no error mark, the
//   queue empties and the registers return to 16 buffers of 4096 bytes at
//   base address 0.
// ----------------------------------------------------------------------------
module dma_buffer_pool_tracker import dbpt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_kind,
   input  logic [7:0]  req_slot_index,
   input  logic [23:0] req_transfer_length,
   input  logic [15:0] req_wait_limit_ms,
   input  logic        req_engine_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_outcome,
   output logic [7:0]  rsp_granted_index,
   output logic [31:0] rsp_byte_offset,
   output logic [31:0] rsp_bus_address
);

   logic [4:0]  pool_buffers_ff;
   logic [24:0] slot_bytes_ff;
   logic [31:0] pool_base_ff;

   cfg_type cfg;
   cmd_type front_cmd;
   cmd_type q_head;
   logic    q_full;
   logic    q_empty;
   logic    q_pop;
   logic    push;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_buffers_ff <= 5'd16;
         slot_bytes_ff   <= 25'd4096;
         pool_base_ff    <= 32'd0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_POOL_BUFFERS: pool_buffers_ff <= csr_data[4:0];
            CSR_SLOT_BYTES:   slot_bytes_ff   <= csr_data[24:0];
            CSR_POOL_BASE:    pool_base_ff    <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.pool_size    = (POOL_W'(pool_buffers_ff) > POOL_W'(MAX_BUFFERS)) ?
                         POOL_W'(MAX_BUFFERS) : POOL_W'(pool_buffers_ff);
      cfg.slot_bytes   = slot_bytes_ff;
      cfg.base_address = pool_base_ff;
   end

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   dbpt_front u_front (
      .cfg             (cfg),
      .kind            (req_kind),
      .slot_index      (req_slot_index),
      .transfer_length (req_transfer_length),
      .wait_limit_ms   (req_wait_limit_ms),
      .engine_ok       (req_engine_ok),
      .cmd             (front_cmd)
   );

   dbpt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_cmd (q_head)
   );

   dbpt_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_empty           (q_empty),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_outcome       (rsp_outcome),
      .rsp_granted_index (rsp_granted_index),
      .rsp_byte_offset   (rsp_byte_offset),
      .rsp_bus_address   (rsp_bus_address)
   );

endmodule

// File: rtl/core/dbpt_checker.sv
// ----------------------------------------------------------------------------
// dbpt_checker
// Port-level checks of the DMA buffer pool tracker, bound to the top level.
// ----------------------------------------------------------------------------
module dbpt_checker import dbpt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_outcome,
   input logic [7:0]  rsp_granted_index,
   input logic [31:0] rsp_byte_offset,
   input logic [31:0] rsp_bus_address
);

   // a stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_outcome) && $stable(rsp_granted_index)
                                 && $stable(rsp_byte_offset) && $stable(rsp_bus_address))
      else $error("response payload changed while stalled");

   // only a response with outcome OK may carry offset and address
   a_addr_only_on_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_outcome != OC_OK |-> rsp_byte_offset == 32'd0
                                            && rsp_bus_address == 32'd0)
      else $error("offset or address on a failed request");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind dma_buffer_pool_tracker dbpt_checker u_dbpt_checker (.*);

// File: verif/dma_buffer_pool_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dma_buffer_pool_tracker_tb
// Self-checking bench for the DMA buffer pool tracker. A short directed table
// walks every request kind and the error paths under the reset settings. The
// bench then runs randomized request streams over several pool settings,
// biased toward reserve, start, finish, complete and release sequences. Every
// reply is compared in order against its table entry or an in-bench model.
// ----------------------------------------------------------------------------
module dma_buffer_pool_tracker_tb;
   import dbpt_pkg::*;

   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
   localparam int NUM_PHASES     = 8;
   localparam int QUIET_PHASE    = 2;
   localparam int HOLD_PHASE     = 5;
   localparam int DRAIN_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_PCT       = 34;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  slot;
      logic [23:0] length;
      logic [15:0] wait_ms;
      logic        eng_ok;
   } request_type;

   typedef struct packed {
      logic [3:0]  outcome;
      logic [7:0]  granted;
      logic [31:0] offset;
      logic [31:0] address;
   } reply_type;

   typedef struct packed {
      request_type req;
      bit          typed;
      reply_type   rep;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = CSR_POOL_BUFFERS;
   logic [31:0] csr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_kind = KIND_RESERVE;
   logic [7:0]  req_slot_index = '0;
   logic [23:0] req_transfer_length = '0;
   logic [15:0] req_wait_limit_ms = '0;
   logic        req_engine_ok = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [3:0]  rsp_outcome;
   logic [7:0]  rsp_granted_index;
   logic [31:0] rsp_byte_offset;
   logic [31:0] rsp_bus_address;

   // pool model
   phase_type   slot_state [MAX_BUFFERS];
   bit          slot_fault [MAX_BUFFERS];
   logic [4:0]  pool_count;
   logic [24:0] slot_size;
   logic [31:0] pool_base;

   reply_type    replies_due[$];
   stim_row_type stim_rows[$];
   int           mismatch_count = 0;
   bit           no_idle = 1'b0;
   int           idle_cycles = 0;

   dma_buffer_pool_tracker u_dut (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_slot_index      (req_slot_index),
      .req_transfer_length (req_transfer_length),
      .req_wait_limit_ms   (req_wait_limit_ms),
      .req_engine_ok       (req_engine_ok),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_outcome         (rsp_outcome),
      .rsp_granted_index   (rsp_granted_index),
      .rsp_byte_offset     (rsp_byte_offset),
      .rsp_bus_address     (rsp_bus_address)
   );

   always #10 clock = ~clock;

   function automatic int unsigned pool_used();
      return (pool_count < MAX_BUFFERS) ? pool_count : MAX_BUFFERS;
   endfunction

   // Applies one request to the pool model and returns its reply.
   function automatic reply_type pool_apply(request_type r);
      reply_type   rep;
      int unsigned used;
      int unsigned i;
      bit          in_pool;
      logic [63:0] prod;
      used        = pool_used();
      in_pool     = (r.slot < used);
      rep.outcome = OC_OK;
      rep.granted = r.slot;
      rep.offset  = '0;
      rep.address = '0;
      case (r.kind)
         KIND_RESERVE: begin
            rep.outcome = OC_NONE_FREE;
            for (i = 0; i < used && rep.outcome == OC_NONE_FREE; i++) begin
               if (slot_state[i] == PH_FREE) begin
                  slot_state[i] = PH_RESERVED;
                  prod          = 64'(i) * 64'(slot_size);
                  rep.outcome   = OC_OK;
                  rep.granted   = 8'(i);
                  rep.offset    = prod[31:0];
                  rep.address   = pool_base + prod[31:0];
               end
            end
         end
         KIND_RELEASE: begin
            if (!in_pool) begin
               rep.outcome = OC_BAD_INDEX;
            end else if (slot_state[r.slot] == PH_FREE) begin
               rep.outcome = OC_NOT_PERMITTED;
            end else begin
               slot_state[r.slot] = PH_FREE;
               slot_fault[r.slot] = 1'b0;
            end
         end
         KIND_START: begin
            if (!in_pool) begin
               rep.outcome = OC_BAD_INDEX;
            end else if (r.length > slot_size) begin
               rep.outcome = OC_TOO_LONG;
            end else if (slot_state[r.slot] == PH_RESERVED) begin
               slot_state[r.slot] = PH_RUNNING;
               slot_fault[r.slot] = 1'b0;
            end else if (slot_state[r.slot] == PH_RUNNING) begin
               rep.outcome = OC_ALREADY;
            end else begin
               rep.outcome = OC_NOT_PERMITTED;
            end
         end
         KIND_FINISH: begin
            if (!in_pool) begin
               rep.outcome = OC_BAD_INDEX;
            end else if (r.wait_ms >= WAIT_LIMIT_MAX) begin
               rep.outcome = OC_BAD_TIMEOUT;
            end else if (slot_state[r.slot] == PH_RUNNING) begin
               rep.outcome = OC_TIMED_OUT;
            end else if (slot_state[r.slot] == PH_DONE) begin
               rep.outcome = slot_fault[r.slot] ? OC_XFER_ERROR : OC_OK;
            end else begin
               rep.outcome = OC_NOT_PERMITTED;
            end
         end
         KIND_COMPLETE: begin
            if (!in_pool) begin
               rep.outcome = OC_BAD_INDEX;
            end else begin
               slot_state[r.slot] = PH_DONE;
               slot_fault[r.slot] = !r.eng_ok;
               rep.outcome        = r.eng_ok ? OC_OK : OC_XFER_ERROR;
            end
         end
         default: rep.outcome = OC_NOT_PERMITTED;
      endcase
      return rep;
   endfunction

   function automatic void add_row(logic [2:0] kind, logic [7:0] slot,
                                   logic [23:0] length = '0, logic [15:0] wait_ms = '0,
                                   logic eng_ok = 1'b0, bit typed = 1'b0,
                                   logic [3:0] oc = OC_OK, logic [7:0] gidx = '0,
                                   logic [31:0] off = '0, logic [31:0] addr = '0);
      stim_row_type row;
      row.req   = '{kind: kind, slot: slot, length: length, wait_ms: wait_ms,
                    eng_ok: eng_ok};
      row.typed = typed;
      row.rep   = '{outcome: oc, granted: gidx, offset: off, address: addr};
      stim_rows.push_back(row);
   endfunction

   // Only called with no request outstanding.
   task automatic program_pool(input logic [4:0] count, input logic [24:0] size,
                               input logic [31:0] base);
      csr_write <= 1'b1;
      csr_index <= CSR_POOL_BUFFERS;
      csr_data  <= 32'(count);
      @(posedge clock);
      csr_index <= CSR_SLOT_BYTES;
      csr_data  <= 32'(size);
      @(posedge clock);
      csr_index <= CSR_POOL_BASE;
      csr_data  <= base;
      @(posedge clock);
      csr_write  <= 1'b0;
      pool_count = count;
      slot_size  = size;
      pool_base  = base;
   endtask

   task automatic send_request(input request_type r, input bit typed,
                               input reply_type fixed);
      reply_type rep;
      int        gap;
      req_valid           <= 1'b1;
      req_kind            <= r.kind;
      req_slot_index      <= r.slot;
      req_transfer_length <= r.length;
      req_wait_limit_ms   <= r.wait_ms;
      req_engine_ok       <= r.eng_ok;
      do @(posedge clock); while (req_stall !== 1'b0);
      rep = pool_apply(r);
      replies_due.push_back(typed ? fixed : rep);
      gap = 0;
      if (!no_idle) begin
         while ($urandom_range(0, 99) < IDLE_PCT) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin : reply_check
      reply_type got;
      reply_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got = '{outcome: rsp_outcome, granted: rsp_granted_index,
                 offset: rsp_byte_offset, address: rsp_bus_address};
         if (replies_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: reply with none pending: oc=%0d idx=%0d off=%h addr=%h",
                        $time, got.outcome, got.granted, got.offset, got.address);
         end else begin
            want = replies_due.pop_front();
            if (got.outcome !== want.outcome || got.granted !== want.granted ||
                got.offset !== want.offset || got.address !== want.address) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: reply mismatch: want oc=%0d idx=%0d off=%h addr=%h, %s",
                           $time, want.outcome, want.granted, want.offset, want.address,
                           $sformatf("got oc=%0d idx=%0d off=%h addr=%h", got.outcome,
                                     got.granted, got.offset, got.address));
            end
         end
      end
   end

   // Ends the run when no transfer happens on either channel for too long.
   initial begin
      wait (reset == 1'b0);
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: watchdog expired, %0d replies pending", $time, replies_due.size());
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      logic [4:0]  cfg_count [NUM_PHASES];
      logic [24:0] cfg_size [NUM_PHASES];
      logic [31:0] cfg_base [NUM_PHASES];
      int          phase_items [NUM_PHASES];
      logic [7:0]  cands[$];
      request_type r;
      logic [23:0] len_cap;
      int unsigned used;
      int          roll;
      int          ph;
      int          n;
      int          i;

      for (i = 0; i < MAX_BUFFERS; i++) begin
         slot_state[i] = PH_FREE;
         slot_fault[i] = 1'b0;
      end
      pool_count = 5'd16;
      slot_size  = 25'd4096;
      pool_base  = 32'd0;

      // one-slot pool of one byte at the top of the address space
      cfg_count[0] = 5'd1;  cfg_size[0] = 25'd1;        cfg_base[0] = 32'hFFFF_FFFF;
      // empty pool
      cfg_count[1] = 5'd0;  cfg_size[1] = 25'h100_0000; cfg_base[1] = $urandom;
      // count above the built depth clamps to 16
      cfg_count[2] = 5'd31; cfg_size[2] = 25'h100_0000; cfg_base[2] = 32'hFFFF_F000;
      cfg_count[3] = 5'd16; cfg_size[3] = 25'h1FF_FFFF; cfg_base[3] = $urandom;
      // zero-size slots: only empty starts pass
      cfg_count[4] = 5'd2;  cfg_size[4] = 25'd0;        cfg_base[4] = 32'd0;
      cfg_count[5] = 5'($urandom_range(1, 16));
      cfg_size[5]  = 25'($urandom_range(1, 4096));
      cfg_base[5]  = $urandom;
      cfg_count[6] = 5'($urandom_range(17, 31));
      cfg_size[6]  = 25'($urandom);
      cfg_base[6]  = $urandom;
      cfg_count[7] = 5'd16; cfg_size[7] = 25'd4096;     cfg_base[7] = $urandom;
      phase_items  = '{200, 60, 230, 230, 200, 230, 230, 230};

      // kind, slot, length, wait, ok, typed, outcome, index, offset, address
      add_row(KIND_FINISH,   8'd0,   24'd0,     16'd0,     1'b0, 1, OC_NOT_PERMITTED, 8'd0);
      add_row(KIND_RELEASE,  8'd0,   24'd0,     16'd0,     1'b0, 1, OC_NOT_PERMITTED, 8'd0);
      add_row(KIND_START,    8'd0,   24'd0,     16'd0,     1'b0, 1, OC_NOT_PERMITTED, 8'd0);
      add_row(KIND_RESERVE,  8'd255, 24'hFFFFFF, 16'hFFFF, 1'b1, 1, OC_OK, 8'd0, 0, 0);
      add_row(KIND_RESERVE,  8'd0,   24'd0,     16'd0,     1'b0, 1, OC_OK, 8'd1, 4096, 4096);
      add_row(KIND_START,    8'd0,   24'd4097,  16'd0,     1'b0, 1, OC_TOO_LONG, 8'd0);
      add_row(KIND_START,    8'd0,   24'd4096);
      add_row(KIND_START,    8'd0,   24'd0,     16'd0,     1'b0, 1, OC_ALREADY, 8'd0);
      add_row(KIND_FINISH,   8'd0,   24'd0,     16'd29999);
      add_row(KIND_FINISH,   8'd0,   24'd0,     16'd30000, 1'b0, 1, OC_BAD_TIMEOUT, 8'd0);
      add_row(KIND_COMPLETE, 8'd0,   24'd0,     16'd0,     1'b0, 1, OC_XFER_ERROR, 8'd0);
      add_row(KIND_FINISH,   8'd0,   24'd0,     16'd0);
      add_row(KIND_START,    8'd0,   24'd1);
      add_row(KIND_COMPLETE, 8'd1,   24'd0,     16'd0,     1'b1);
      add_row(KIND_FINISH,   8'd1,   24'd0,     16'd100);
      add_row(KIND_RELEASE,  8'd0);
      add_row(KIND_RELEASE,  8'd16,  24'd0,     16'd0,     1'b0, 1, OC_BAD_INDEX, 8'd16);
      add_row(KIND_START,    8'd255, 24'd0,     16'd0,     1'b0, 1, OC_BAD_INDEX, 8'd255);
      add_row(KIND_FINISH,   8'd255, 24'd0,     16'd0,     1'b0, 1, OC_BAD_INDEX, 8'd255);
      add_row(KIND_COMPLETE, 8'd16,  24'd0,     16'd0,     1'b1, 1, OC_BAD_INDEX, 8'd16);
      add_row(KIND_SPARE_FIRST, 8'd3, 24'd0,    16'd0,     1'b0, 1, OC_NOT_PERMITTED, 8'd3);
      add_row(KIND_SPARE_LAST, 8'd200, 24'd0,   16'd0,     1'b1, 1, OC_NOT_PERMITTED, 8'd200);
      add_row(KIND_COMPLETE, 8'd15,  24'd0,     16'd0,     1'b1);
      add_row(KIND_FINISH,   8'd15);
      add_row(KIND_RESERVE,  8'd9);
      add_row(KIND_RELEASE,  8'd1);

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[k])
         send_request(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].rep);

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         req_valid <= 1'b0;
         while (replies_due.size() != 0) @(posedge clock);
         repeat (DRAIN_CYCLES) @(posedge clock);
         program_pool(cfg_count[ph], cfg_size[ph], cfg_base[ph]);
         no_idle = (ph == QUIET_PHASE);
         used    = pool_used();
         len_cap = (slot_size > 25'hFF_FFFF) ? 24'hFF_FFFF : slot_size[23:0];

         for (n = 0; n < phase_items[ph]; n++) begin
            // hold off mid-phase until the pipe is empty
            if (ph == HOLD_PHASE && n == phase_items[ph] / 2) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (replies_due.size() != 0);
            end

            roll = $urandom_range(0, 99);
            if (roll < 22)      r.kind = KIND_RESERVE;
            else if (roll < 38) r.kind = KIND_RELEASE;
            else if (roll < 58) r.kind = KIND_START;
            else if (roll < 76) r.kind = KIND_FINISH;
            else if (roll < 96) r.kind = KIND_COMPLETE;
            else                r.kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));

            // steer toward slots whose phase lets this kind make progress
            cands.delete();
            for (i = 0; i < used; i++) begin
               case (r.kind)
                  KIND_RELEASE:  if (slot_state[i] != PH_FREE) cands.push_back(8'(i));
                  KIND_START:    if (slot_state[i] == PH_RESERVED) cands.push_back(8'(i));
                  KIND_FINISH:   if (slot_state[i] inside {PH_RUNNING, PH_DONE})
                                    cands.push_back(8'(i));
                  KIND_COMPLETE: if (slot_state[i] inside {PH_RUNNING, PH_RESERVED})
                                    cands.push_back(8'(i));
                  default: ;
               endcase
            end
            roll = $urandom_range(0, 99);
            if (roll < 70 && cands.size() != 0)
               r.slot = cands[$urandom_range(0, cands.size() - 1)];
            else if (roll < 90 && used != 0)
               r.slot = 8'($urandom_range(0, used - 1));
            else
               r.slot = 8'($urandom_range(0, 255));

            r.length  = ($urandom_range(0, 99) < 80) ? 24'($urandom_range(0, len_cap))
                                                     : 24'($urandom);
            r.wait_ms = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, 29999))
                                                     : 16'($urandom);
            r.eng_ok  = ($urandom_range(0, 99) < 75);
            send_request(r, 1'b0, '0);
         end
      end

      req_valid <= 1'b0;
      no_idle = 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/dbpt_pkg.sv
rtl/core/dbpt_front.sv
rtl/core/dbpt_queue.sv
rtl/core/dbpt_back.sv
rtl/core/dma_buffer_pool_tracker.sv
rtl/core/dbpt_checker.sv
verif/dma_buffer_pool_tracker_tb.sv
